### sv/btsd_pkg.sv
`default_nettype none

package btsd_pkg;

   localparam int unsigned KIND_WIDTH  = 5;
   localparam int unsigned VALUE_WIDTH = 64;

   localparam logic [KIND_WIDTH-1:0] EV_LINE_START = 5'd0;
   localparam logic [KIND_WIDTH-1:0] EV_LINE_END   = 5'd1;
   localparam logic [KIND_WIDTH-1:0] EV_PROG_END   = 5'd2;
   localparam logic [KIND_WIDTH-1:0] EV_CHAR       = 5'd3;
   localparam logic [KIND_WIDTH-1:0] EV_KEYWORD    = 5'd4;
   localparam logic [KIND_WIDTH-1:0] EV_EXT_KW     = 5'd5;
   localparam logic [KIND_WIDTH-1:0] EV_IEEE       = 5'd6;
   localparam logic [KIND_WIDTH-1:0] EV_OCTAL      = 5'd7;
   localparam logic [KIND_WIDTH-1:0] EV_HEX        = 5'd8;
   localparam logic [KIND_WIDTH-1:0] EV_UNSIGNED   = 5'd9;
   localparam logic [KIND_WIDTH-1:0] EV_SIGNED     = 5'd10;
   localparam logic [KIND_WIDTH-1:0] EV_FLOAT4     = 5'd11;
   localparam logic [KIND_WIDTH-1:0] EV_FLOAT8     = 5'd12;
   localparam logic [KIND_WIDTH-1:0] EV_ABS_ADDR   = 5'd13;
   localparam logic [KIND_WIDTH-1:0] EV_UNKNOWN    = 5'd14;
   localparam logic [KIND_WIDTH-1:0] EV_BREAK      = 5'd15;
   localparam logic [KIND_WIDTH-1:0] EV_EOF_ERROR  = 5'd16;

   localparam logic [7:0] TOK_END_LINE   = 8'h00;
   localparam logic [7:0] TOK_OCTAL      = 8'h0b;
   localparam logic [7:0] TOK_HEX        = 8'h0c;
   localparam logic [7:0] TOK_ABS_ADDR   = 8'h0d;
   localparam logic [7:0] TOK_LINE_REF   = 8'h0e;
   localparam logic [7:0] TOK_BYTE       = 8'h0f;
   localparam logic [7:0] TOK_DIGIT_LO   = 8'h11;
   localparam logic [7:0] TOK_DIGIT_HI   = 8'h1a;
   localparam logic [7:0] TOK_SIGNED     = 8'h1c;
   localparam logic [7:0] TOK_FLOAT4     = 8'h1d;
   localparam logic [7:0] TOK_FLOAT8     = 8'h1f;
   localparam logic [7:0] TOK_KW_FIRST   = 8'h81;
   localparam logic [7:0] TOK_KW_LAST    = 8'hfe;
   localparam logic [7:0] TOK_EXT_LAST   = 8'hfd;
   localparam logic [7:0] TOK_EXT_PREFIX = 8'hff;
   localparam logic [7:0] TOK_REM        = 8'h8f;
   localparam logic [7:0] TOK_DATA       = 8'h84;
   localparam logic [7:0] TOK_EXT_IEEE   = 8'hec;
   localparam logic [7:0] CHR_PRINT_LO   = 8'h20;
   localparam logic [7:0] CHR_PRINT_HI   = 8'h7e;
   localparam logic [7:0] CHR_QUOTE      = 8'h22;
   localparam logic [7:0] CHR_COLON      = 8'h3a;
   localparam logic [7:0] CHR_KANA_LO    = 8'ha1;
   localparam logic [7:0] CHR_KANA_HI    = 8'hdf;
   localparam logic [7:0] EXT_KEYWORD_MAX = 8'd44;

   localparam logic [15:0] SIGN_BIT_MASK = 16'h8000;

   typedef struct packed {
      logic                   valid;
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] value;
   } event_type;

endpackage

`default_nettype wire

### sv/basic_token_stream_decoder.sv
// Decoder for a tokenized BASIC program stream.
// The req_ channel carries one program byte per request in req_tdata, with
// req_tuser set on the request that marks end of input. The rsp_ channel
// carries one decoded event per request that produces one: the event kind in
// rsp_tuser and the line number, character, keyword index, constant or raw
// float bytes in rsp_tdata. Many requests (link bytes, constant bytes) produce
// no event at all.
// The csr_ channel writes the single mode bit; set it to report colons
// outside quotes as statement breaks. Write it only while the block is idle.
// A request is held in the input register and decoded against the parse
// state on its way to the result register, from which its event is presented
// on the rsp_ channel. One request is taken every cycle while rsp_tready
// stays high.
// When the receiver stalls, the result register holds its event and the
// input register takes one more request, after which req_tready drops until
// rsp_tready rises.
// Synchronous reset empties both registers, returns the parser to the start
// of a line and clears the mode bit. After program end or end of input the
// block consumes and drops every request until the next reset.
`default_nettype none

module basic_token_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic [0:0]  req_tuser,   // [0] end_of_input
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [63:0] event_value
   output      logic [4:0]  rsp_tuser,   // [4:0] event_kind
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [0:0]  csr_data     // [0] pretty_mode
);
   import btsd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;
   logic        out_valid_ff, out_valid_in;
   logic [KIND_WIDTH-1:0]  out_kind_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic        pretty_ff;
   logic        advance;
   event_type   decoded;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign csr_ready   = 1'b1;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_comb begin
      if (advance) begin
         out_valid_in = decoded.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pretty_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            pretty_ff <= csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tuser[0];
      end
      if (advance && decoded.valid) begin
         out_kind_ff  <= decoded.kind;
         out_value_ff <= decoded.value;
      end
   end

   btsd_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .byte_value   (in_byte_ff),
      .end_of_input (in_eof_ff),
      .pretty_mode  (pretty_ff),
      .event_out    (decoded)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTH
   a_ready_when_output_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the result register is empty");

   a_kind_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= EV_EOF_ERROR)
      else $error("event kind out of range");

   a_signed_extended: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_SIGNED |-> rsp_tdata[63:16] == {48{rsp_tdata[15]}})
      else $error("signed constant not sign extended");

   a_empty_kinds_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_LINE_END || rsp_tuser == EV_PROG_END
                     || rsp_tuser == EV_IEEE || rsp_tuser == EV_EOF_ERROR)
      |-> rsp_tdata == 64'd0)
      else $error("event without value carries nonzero data");
`endif

endmodule

`default_nettype wire

### sv/btsd_decoder.sv
`default_nettype none

module btsd_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [7:0]         byte_value,
   input  wire logic               end_of_input,
   input  wire logic               pretty_mode,
   output      btsd_pkg::event_type event_out
);
   import btsd_pkg::*;

   localparam logic [2:0] PH_LINK_LO = 3'd0;
   localparam logic [2:0] PH_LINK_HI = 3'd1;
   localparam logic [2:0] PH_NUM_LO  = 3'd2;
   localparam logic [2:0] PH_NUM_HI  = 3'd3;
   localparam logic [2:0] PH_BODY    = 3'd4;
   localparam logic [2:0] PH_OPERAND = 3'd5;
   localparam logic [2:0] PH_EXT     = 3'd6;
   localparam logic [2:0] PH_HALTED  = 3'd7;

   logic [2:0]            phase_ff, phase_in;
   logic                  link_zero_ff, link_zero_in;
   logic [7:0]            line_low_ff, line_low_in;
   logic [63:0]           operand_ff, operand_in;
   logic [3:0]            remaining_ff, remaining_in;
   logic [3:0]            length_ff, length_in;
   logic [KIND_WIDTH-1:0] pending_ff, pending_in;
   logic                  quote_ff, quote_in;
   logic                  remark_ff, remark_in;

   logic       plain;
   logic [2:0] pos;
   logic [7:0] offset;
   logic [63:0] merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINK_LO;
         link_zero_ff <= 1'b0;
         line_low_ff  <= 8'd0;
         operand_ff   <= 64'd0;
         remaining_ff <= 4'd0;
         length_ff    <= 4'd0;
         pending_ff   <= EV_LINE_START;
         quote_ff     <= 1'b0;
         remark_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         link_zero_ff <= link_zero_in;
         line_low_ff  <= line_low_in;
         operand_ff   <= operand_in;
         remaining_ff <= remaining_in;
         length_ff    <= length_in;
         pending_ff   <= pending_in;
         quote_ff     <= quote_in;
         remark_ff    <= remark_in;
      end
   end

   assign plain  = !quote_ff && !remark_ff;
   assign pos    = 3'(length_ff - remaining_ff);
   assign offset = byte_value - TOK_KW_FIRST;
   assign merged = operand_ff | ({56'd0, byte_value} << {pos, 3'b000});

   always_comb begin
      phase_in     = phase_ff;
      link_zero_in = link_zero_ff;
      line_low_in  = line_low_ff;
      operand_in   = operand_ff;
      remaining_in = remaining_ff;
      length_in    = length_ff;
      pending_in   = pending_ff;
      quote_in     = quote_ff;
      remark_in    = remark_ff;
      event_out    = '{valid: 1'b0, kind: EV_LINE_START, value: 64'd0};

      if (phase_ff == PH_HALTED) begin
         phase_in = PH_HALTED;
      end else if (end_of_input) begin
         phase_in  = PH_HALTED;
         event_out = '{valid: 1'b1, kind: EV_EOF_ERROR, value: 64'd0};
      end else begin
         unique case (phase_ff)
            PH_LINK_LO: begin
               link_zero_in = (byte_value == 8'd0);
               phase_in     = PH_LINK_HI;
            end
            PH_LINK_HI: begin
               if (link_zero_ff && byte_value == 8'd0) begin
                  phase_in  = PH_HALTED;
                  event_out = '{valid: 1'b1, kind: EV_PROG_END, value: 64'd0};
               end else begin
                  phase_in = PH_NUM_LO;
               end
            end
            PH_NUM_LO: begin
               line_low_in = byte_value;
               phase_in    = PH_NUM_HI;
            end
            PH_NUM_HI: begin
               quote_in  = 1'b0;
               remark_in = 1'b0;
               phase_in  = PH_BODY;
               event_out = '{valid: 1'b1, kind: EV_LINE_START,
                             value: {48'd0, byte_value, line_low_ff}};
            end
            PH_OPERAND: begin
               operand_in = merged;
               if (remaining_ff != 4'd0) begin
                  remaining_in = remaining_ff - 4'd1;
               end
               if (remaining_in == 4'd0) begin
                  phase_in  = PH_BODY;
                  event_out = '{valid: 1'b1, kind: pending_ff, value: merged};
                  if (pending_ff == EV_SIGNED && (merged[15:0] & SIGN_BIT_MASK) != 16'd0) begin
                     event_out.value = {48'hffff_ffff_ffff, merged[15:0]};
                  end
               end
            end
            PH_EXT: begin
               phase_in = PH_BODY;
               priority if (byte_value == TOK_EXT_IEEE) begin
                  event_out = '{valid: 1'b1, kind: EV_IEEE, value: 64'd0};
               end else if (byte_value >= TOK_KW_FIRST && byte_value <= TOK_EXT_LAST) begin
                  if (offset <= EXT_KEYWORD_MAX) begin
                     event_out = '{valid: 1'b1, kind: EV_EXT_KW, value: {56'd0, offset}};
                  end else begin
                     event_out = '{valid: 1'b1, kind: EV_UNKNOWN, value: {56'd0, byte_value}};
                  end
               end else begin
                  event_out.valid = 1'b0;
               end
            end
            default: begin
               priority if (byte_value == TOK_END_LINE) begin
                  phase_in  = PH_LINK_LO;
                  event_out = '{valid: 1'b1, kind: EV_LINE_END, value: 64'd0};
               end else if (byte_value == TOK_OCTAL || byte_value == TOK_HEX
                            || byte_value == TOK_ABS_ADDR || byte_value == TOK_LINE_REF
                            || byte_value == TOK_BYTE || byte_value == TOK_SIGNED
                            || byte_value == TOK_FLOAT4 || byte_value == TOK_FLOAT8) begin
                  phase_in   = PH_OPERAND;
                  operand_in = 64'd0;
                  unique case (byte_value)
                     TOK_OCTAL:    begin pending_in = EV_OCTAL;    length_in = 4'd2; end
                     TOK_HEX:      begin pending_in = EV_HEX;      length_in = 4'd2; end
                     TOK_ABS_ADDR: begin pending_in = EV_ABS_ADDR; length_in = 4'd2; end
                     TOK_LINE_REF: begin pending_in = EV_UNSIGNED; length_in = 4'd2; end
                     TOK_BYTE:     begin pending_in = EV_UNSIGNED; length_in = 4'd1; end
                     TOK_SIGNED:   begin pending_in = EV_SIGNED;   length_in = 4'd2; end
                     TOK_FLOAT4:   begin pending_in = EV_FLOAT4;   length_in = 4'd4; end
                     default:      begin pending_in = EV_FLOAT8;   length_in = 4'd8; end
                  endcase
                  remaining_in = length_in;
               end else if (byte_value >= TOK_DIGIT_LO && byte_value <= TOK_DIGIT_HI) begin
                  event_out = '{valid: 1'b1, kind: EV_UNSIGNED,
                                value: {56'd0, byte_value - TOK_DIGIT_LO}};
               end else if (byte_value >= TOK_KW_FIRST && byte_value <= TOK_KW_LAST && plain) begin
                  if (byte_value == TOK_REM || byte_value == TOK_DATA) begin
                     remark_in = 1'b1;
                  end
                  event_out = '{valid: 1'b1, kind: EV_KEYWORD, value: {56'd0, offset}};
               end else if (byte_value == TOK_EXT_PREFIX && plain) begin
                  phase_in = PH_EXT;
               end else if (byte_value >= CHR_PRINT_LO && byte_value <= CHR_PRINT_HI) begin
                  event_out = '{valid: 1'b1, kind: EV_CHAR, value: {56'd0, byte_value}};
                  if (byte_value == CHR_QUOTE) begin
                     quote_in = !quote_ff;
                  end else if (!quote_ff && byte_value == CHR_COLON) begin
                     remark_in = 1'b0;
                     if (pretty_mode) begin
                        event_out.kind = EV_BREAK;
                     end
                  end
               end else if (byte_value >= CHR_KANA_LO && byte_value <= CHR_KANA_HI) begin
                  event_out = '{valid: 1'b1, kind: EV_CHAR, value: {56'd0, byte_value}};
               end else begin
                  event_out = '{valid: 1'b1, kind: EV_UNKNOWN, value: {56'd0, byte_value}};
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
   import btsd_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   typedef enum logic [2:0] {
      AT_LINK_LO, AT_LINK_HI, AT_NUM_LO, AT_NUM_HI,
      AT_BODY, AT_OPERAND, AT_EXT, AT_HALTED
   } parse_phase_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] value;
   } decoded_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_data = '0;

   // Shadow copy of the decoder state.
   parse_phase_type        phase = AT_LINK_LO;
   logic                   link_lo_zero = 1'b0;
   logic [7:0]             line_lo = '0;
   logic [VALUE_WIDTH-1:0] operand_value = '0;
   int unsigned            operand_left = 0;
   int unsigned            operand_len = 0;
   logic [KIND_WIDTH-1:0]  operand_kind = '0;
   logic                   in_quote = 1'b0;
   logic                   in_remark = 1'b0;
   logic                   mode_pretty = 1'b0;

   decoded_event_type pending_events[$];
   decoded_event_type want;
   int unsigned    mismatches = 0;
   int unsigned    bytes_sent = 0;
   int unsigned    stall_cycles = 0;
   int unsigned    req_idle_pct = 22;
   int unsigned    rsp_stall_pct = 81;

   basic_token_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic add_event(input logic [KIND_WIDTH-1:0] kind,
                            input logic [VALUE_WIDTH-1:0] value);
      pending_events.push_back('{kind: kind, value: value});
   endtask

   task automatic open_operand(input logic [KIND_WIDTH-1:0] kind, input int unsigned len);
      operand_kind = kind;
      operand_len = len;
      operand_left = len;
      operand_value = '0;
      phase = AT_OPERAND;
   endtask

   task automatic predict_event(input logic [7:0] b, input logic eof);
      logic                   plain;
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] v;
      logic [7:0]             idx;
      plain = !in_quote && !in_remark;
      if (phase == AT_HALTED) return;
      if (eof) begin
         phase = AT_HALTED;
         add_event(EV_EOF_ERROR, '0);
         return;
      end
      case (phase)
         AT_LINK_LO: begin
            link_lo_zero = (b == '0);
            phase = AT_LINK_HI;
         end
         AT_LINK_HI: begin
            if (link_lo_zero && b == '0) begin
               phase = AT_HALTED;
               add_event(EV_PROG_END, '0);
            end else begin
               phase = AT_NUM_LO;
            end
         end
         AT_NUM_LO: begin
            line_lo = b;
            phase = AT_NUM_HI;
         end
         AT_NUM_HI: begin
            in_quote = 1'b0;
            in_remark = 1'b0;
            phase = AT_BODY;
            add_event(EV_LINE_START, {48'd0, b, line_lo});
         end
         AT_OPERAND: begin
            operand_value[8*(operand_len-operand_left) +: 8] = b;
            operand_left--;
            if (operand_left == 0) begin
               phase = AT_BODY;
               v = operand_value;
               if (operand_kind == EV_SIGNED && v[15]) v[63:16] = '1;
               add_event(operand_kind, v);
            end
         end
         AT_EXT: begin
            phase = AT_BODY;
            idx = b - TOK_KW_FIRST;
            if (b == TOK_EXT_IEEE) begin
               add_event(EV_IEEE, '0);
            end else if (b >= TOK_KW_FIRST && b <= TOK_EXT_LAST) begin
               if (idx <= EXT_KEYWORD_MAX) add_event(EV_EXT_KW, {56'd0, idx});
               else add_event(EV_UNKNOWN, {56'd0, b});
            end
         end
         default: begin
            case (b)
               TOK_END_LINE: begin
                  phase = AT_LINK_LO;
                  add_event(EV_LINE_END, '0);
               end
               TOK_OCTAL:    open_operand(EV_OCTAL, 2);
               TOK_HEX:      open_operand(EV_HEX, 2);
               TOK_ABS_ADDR: open_operand(EV_ABS_ADDR, 2);
               TOK_LINE_REF: open_operand(EV_UNSIGNED, 2);
               TOK_BYTE:     open_operand(EV_UNSIGNED, 1);
               TOK_SIGNED:   open_operand(EV_SIGNED, 2);
               TOK_FLOAT4:   open_operand(EV_FLOAT4, 4);
               TOK_FLOAT8:   open_operand(EV_FLOAT8, 8);
               default: begin
                  if (b >= TOK_DIGIT_LO && b <= TOK_DIGIT_HI) begin
                     idx = b - TOK_DIGIT_LO;
                     add_event(EV_UNSIGNED, {56'd0, idx});
                  end else if (b >= TOK_KW_FIRST && b <= TOK_KW_LAST && plain) begin
                     if (b == TOK_REM || b == TOK_DATA) in_remark = 1'b1;
                     idx = b - TOK_KW_FIRST;
                     add_event(EV_KEYWORD, {56'd0, idx});
                  end else if (b == TOK_EXT_PREFIX && plain) begin
                     phase = AT_EXT;
                  end else if (b >= CHR_PRINT_LO && b <= CHR_PRINT_HI) begin
                     kind = EV_CHAR;
                     if (b == CHR_QUOTE) begin
                        in_quote = !in_quote;
                     end else if (!in_quote && b == CHR_COLON) begin
                        in_remark = 1'b0;
                        if (mode_pretty) kind = EV_BREAK;
                     end
                     add_event(kind, {56'd0, b});
                  end else if (b >= CHR_KANA_LO && b <= CHR_KANA_HI) begin
                     add_event(EV_CHAR, {56'd0, b});
                  end else begin
                     add_event(EV_UNKNOWN, {56'd0, b});
                  end
               end
            endcase
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= eof;
      do @(posedge clock); while (!req_tready);
      predict_event(b, eof);
      bytes_sent++;
   endtask

   task automatic wait_idle(input int unsigned settle);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(input logic pretty);
      wait_idle(4);
      csr_valid <= 1'b1;
      csr_data <= pretty;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_pretty = pretty;
   endtask

   task automatic send_header();
      logic [7:0]  link_lo;
      logic [15:0] number;
      link_lo = 8'($urandom_range(0, 255));
      send_byte(link_lo, 1'b0);
      // A zero low link byte must be followed by a nonzero one, or the program ends.
      send_byte(8'(link_lo == '0 ? $urandom_range(1, 255) : $urandom_range(0, 255)), 1'b0);
      case ($urandom_range(0, 7))
         0: number = 16'h0000;
         1: number = 16'hffff;
         default: number = 16'($urandom_range(0, 65535));
      endcase
      send_byte(number[7:0], 1'b0);
      send_byte(number[15:8], 1'b0);
   endtask

   task automatic send_token();
      logic [7:0]  prefix;
      int unsigned len;
      case ($urandom_range(0, 15))
         0, 1, 2: send_byte(8'($urandom_range(CHR_PRINT_LO, CHR_PRINT_HI)), 1'b0);
         3:       send_byte(CHR_QUOTE, 1'b0);
         4:       send_byte(CHR_COLON, 1'b0);
         5:       send_byte(8'($urandom_range(CHR_KANA_LO, CHR_KANA_HI)), 1'b0);
         6, 7:    send_byte(8'($urandom_range(TOK_KW_FIRST, TOK_KW_LAST)), 1'b0);
         8:       send_byte($urandom_range(0, 1) ? TOK_REM : TOK_DATA, 1'b0);
         9: begin
            send_byte(TOK_EXT_PREFIX, 1'b0);
            case ($urandom_range(0, 3))
               0:       send_byte(TOK_EXT_IEEE, 1'b0);
               3:       send_byte(8'($urandom_range(0, 255)), 1'b0);
               default: send_byte(8'($urandom_range(TOK_KW_FIRST,
                                                    TOK_KW_FIRST + EXT_KEYWORD_MAX + 2)),
                                  1'b0);
            endcase
         end
         10: send_byte(8'($urandom_range(TOK_DIGIT_LO, TOK_DIGIT_HI)), 1'b0);
         11, 12: begin
            case ($urandom_range(0, 7))
               0: begin prefix = TOK_OCTAL;    len = 2; end
               1: begin prefix = TOK_HEX;      len = 2; end
               2: begin prefix = TOK_ABS_ADDR; len = 2; end
               3: begin prefix = TOK_LINE_REF; len = 2; end
               4: begin prefix = TOK_BYTE;     len = 1; end
               5: begin prefix = TOK_SIGNED;   len = 2; end
               6: begin prefix = TOK_FLOAT4;   len = 4; end
               default: begin prefix = TOK_FLOAT8; len = 8; end
            endcase
            send_byte(prefix, 1'b0);
            repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         default: send_byte(8'($urandom_range(1, 255)), 1'b0);
      endcase
   endtask

   task automatic send_line(input int unsigned tokens);
      send_header();
      repeat (tokens) send_token();
      // A stray prefix byte would swallow the line end, so finish its operand first.
      while (phase == AT_OPERAND || phase == AT_EXT) send_byte(8'($urandom_range(1, 255)), 1'b0);
      send_byte(TOK_END_LINE, 1'b0);
   endtask

   task automatic test_directed_tokens();
      logic [7:0] seq[];
      write_mode(1'b0);
      // Constants inside quotes, the remark mode, extended tokens out of range.
      seq = {8'h00, 8'hff, 8'hff, 8'hff,
             CHR_QUOTE, TOK_OCTAL, 8'h34, 8'h12, CHR_QUOTE, CHR_COLON,
             TOK_REM, TOK_KW_FIRST, CHR_COLON,
             TOK_EXT_PREFIX, TOK_EXT_IEEE,
             TOK_EXT_PREFIX, TOK_KW_FIRST + EXT_KEYWORD_MAX + 8'd1,
             TOK_EXT_PREFIX, TOK_END_LINE,
             TOK_SIGNED, 8'h00, 8'h80, TOK_END_LINE};
      foreach (seq[i]) send_byte(seq[i], 1'b0);
   endtask

   task automatic test_statement_breaks();
      logic [7:0] seq[];
      write_mode(1'b1);
      seq = {8'h01, 8'h00, 8'h00, 8'h00,
             CHR_COLON, TOK_DATA, CHR_QUOTE, CHR_COLON, CHR_QUOTE,
             TOK_FLOAT8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
             8'h7f, TOK_END_LINE};
      foreach (seq[i]) send_byte(seq[i], 1'b0);
   endtask

   task automatic test_random_program(input int unsigned count, input logic pretty);
      int unsigned start;
      write_mode(pretty);
      start = bytes_sent;
      while (bytes_sent - start < count) send_line($urandom_range(0, 12));
   endtask

   task automatic test_stream_end();
      int unsigned cut;
      cut = $urandom_range(0, 5);
      case (cut)
         0: begin
            send_byte('0, 1'b0);
            send_byte('0, 1'b0);
         end
         1: ;
         2: send_byte(8'($urandom_range(0, 255)), 1'b0);
         3: begin
            send_header();
            repeat ($urandom_range(0, 4)) send_token();
         end
         4: begin
            send_header();
            send_byte(TOK_FLOAT8, 1'b0);
            repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         default: begin
            send_header();
            send_byte(TOK_EXT_PREFIX, 1'b0);
         end
      endcase
      if (cut != 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      // Once halted, the decoder drops every request.
      repeat (16) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected event: kind %0d value %h", rsp_tuser, rsp_tdata);
         end else begin
            want = pending_events.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("event mismatch: expected kind %0d value %h, got kind %0d value %h",
                           want.kind, want.value, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_statement_breaks();
      test_random_program(650, 1'b1);
      req_idle_pct = 81;
      rsp_stall_pct = 22;
      test_random_program(650, 1'b0);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_program(650, 1'b1);
      test_stream_end();
      wait_idle(8);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
